/* design/cet_pkg.sv */
// Shared types and constants for the calorimeter event trigger filter.
`timescale 1ns / 1ps
package cet_pkg;

	localparam int MAX_STORED_DEF = 64;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_E     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHOTON    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ELECTRON  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MASS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NBAR_MIN  = 3'd4;

	localparam logic [15:0] RST_MIN_E     = 16'd300;
	localparam logic [15:0] RST_PHOTON    = 16'd2200;
	localparam logic [15:0] RST_ELECTRON  = 16'd1000;
	localparam logic [11:0] RST_PAIR_MASS = 12'd350;
	localparam logic [7:0]  RST_NBAR_MIN  = 8'd2;

	// track distance in 1/16 sigma, dispersions in 1/256
	localparam logic [9:0]  TD_ONE_SIGMA  = 10'd16;
	localparam logic [9:0]  TD_TWO_SIGMA  = 10'd32;
	localparam logic [7:0]  NBAR_MIN_CELLS = 8'd2;
	localparam logic [11:0] NBAR_MIN_DISP = 12'd52;
	localparam logic [15:0] NBAR_MIN_E    = 16'd700;
	localparam logic [15:0] NBAR_SPLIT_E  = 16'd2000;
	localparam logic [12:0] NBAR_DSUM_LO  = 13'd1152;
	localparam logic [12:0] NBAR_DSUM_HI  = 13'd1024;

	typedef struct packed {
		logic        [15:0] e;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
	} entry_t;

endpackage

/* design/cet_cell.sv */
// One store cell: holds one cluster and passes it to its neighbor on shift.
`timescale 1ns / 1ps
module cet_cell
	import cet_pkg::*;
(
	input  logic   clk,
	input  logic   shift_en,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

/* design/cet_mass.sv */
// Pipelined pair mass-squared check of a probe cluster against stored clusters.
`timescale 1ns / 1ps
module cet_mass
	import cet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  entry_t      stored,
	input  entry_t      probe,
	input  logic [23:0] thr,
	output logic        hit
);

	logic               v_s1, v_s2, v_s3;
	logic        [16:0] se_s1;
	logic signed [16:0] sx_s1, sy_s1, sz_s1;
	logic        [33:0] se2_s2;
	logic        [33:0] sx2_s2, sy2_s2, sz2_s2;
	logic signed [35:0] a_s3, b_s3;
	logic signed [36:0] m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		se_s1  <= {1'b0, stored.e} + {1'b0, probe.e};
		sx_s1  <= 17'(stored.px) + 17'(probe.px);
		sy_s1  <= 17'(stored.py) + 17'(probe.py);
		sz_s1  <= 17'(stored.pz) + 17'(probe.pz);
		se2_s2 <= se_s1 * se_s1;
		sx2_s2 <= 34'(sx_s1 * sx_s1);
		sy2_s2 <= 34'(sy_s1 * sy_s1);
		sz2_s2 <= 34'(sz_s1 * sz_s1);
		a_s3   <= $signed({2'b00, se2_s2}) - $signed({2'b00, sx2_s2});
		b_s3   <= $signed({2'b00, sy2_s2}) + $signed({2'b00, sz2_s2});
	end

	assign m   = 37'(a_s3) - 37'(b_s3);
	assign hit = v_s3 && (m > $signed({13'd0, thr}));

endmodule

/* design/calorimeter_event_trigger_filter.sv */
// Flow: an item passes IDLE, EVAL and CLOSE, with SCAN and DRAIN between when it is paired with the store;
//   the event tag is valid in the cycle after the closing item is done.
// A new item is accepted only once the last one is done; a pair search rotates
//   the whole cell ring once, one cell per cycle, through a single mass unit.
// A closing item holds in its last cycle while the previous tag still waits on the output.
// Reset: arst_n clears control, flags and counts and restores the default configuration; store contents are kept.
`timescale 1ns / 1ps
module calorimeter_event_trigger_filter
	import cet_pkg::*;
#(
	parameter int MAX_STORED = MAX_STORED_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// energy, mom_x, mom_y, mom_z, track_distance, cell_count, disp_long, disp_short
	input  logic [111:0]          s_axis_tdata,
	input  logic                  s_axis_tlast,
	// no_cluster
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// photon_flag, electron_flag, pair_flag, nbar_flag, had_clusters, store_overflow
	output logic [7:0]            m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_STORED + 1);
	localparam int K_W   = (MAX_STORED > 1) ? $clog2(MAX_STORED) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EVAL  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_CLOSE = 5'b10000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic [5:0] out_q;

	logic [15:0] cfg_min_e_q, cfg_phot_q, cfg_el_q;
	logic [11:0] cfg_pair_q;
	logic [7:0]  cfg_nbar_q;

	entry_t      probe_q;
	logic [9:0]  td_q;
	logic [7:0]  nc_q;
	logic [11:0] dl_q, ds_q;
	logic        last_q, empty_q;

	logic [CNT_W-1:0] count_q;
	logic [K_W-1:0]   k_q;
	logic [1:0]       drain_q;
	logic [23:0]      thr_q;
	logic photon_q, electron_q, pair_q, any_q, ovf_q;
	logic [7:0] nbar_q;

	entry_t ring [MAX_STORED];
	entry_t head_d;
	logic   shift_en, store_en, scanning, scan_valid, hit;

	logic        take, nbar_hit, tag_load;
	logic [12:0] dsum;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

	// load a new tag only when the output slot is free or being emptied
	assign tag_load = (state_q == ST_CLOSE) && last_q && (!out_valid_q || m_axis_tready);

	// cell ring: new entries enter at the head; a scan wraps the tail back to the head
	assign scanning = (state_q == ST_SCAN);
	assign head_d   = scanning ? ring[MAX_STORED-1] : probe_q;
	assign shift_en = scanning || store_en;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_STORED; gi++) begin : g_cell
			cet_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        ((gi == 0) ? head_d : ring[(gi == 0) ? 0 : gi-1]),
				.q        (ring[gi])
			);
		end
	endgenerate

	// at step k the tail holds position MAX_STORED-1-k, valid when below count
	assign scan_valid = scanning &&
		((CNT_W+1)'(k_q) + (CNT_W+1)'(count_q) >= (CNT_W+1)'(MAX_STORED));

	cet_mass u_mass (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (scan_valid),
		.stored   (ring[MAX_STORED-1]),
		.probe    (probe_q),
		.thr      (thr_q),
		.hit      (hit)
	);

	assign take = (state_q == ST_EVAL) && !empty_q && (probe_q.e > cfg_min_e_q);
	assign dsum = {1'b0, dl_q} + {1'b0, ds_q};
	assign nbar_hit = (nc_q > NBAR_MIN_CELLS) && (dl_q >= NBAR_MIN_DISP) &&
		(probe_q.e > NBAR_MIN_E) && (td_q > TD_TWO_SIGMA) &&
		(((probe_q.e < NBAR_SPLIT_E) && (dsum > NBAR_DSUM_LO)) ||
		 ((probe_q.e > NBAR_SPLIT_E) && (dsum > NBAR_DSUM_HI)));
	assign store_en = take && !pair_q && (td_q < TD_ONE_SIGMA) &&
		(count_q < CNT_W'(MAX_STORED));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min_e_q <= RST_MIN_E;
			cfg_phot_q  <= RST_PHOTON;
			cfg_el_q    <= RST_ELECTRON;
			cfg_pair_q  <= RST_PAIR_MASS;
			cfg_nbar_q  <= RST_NBAR_MIN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MIN_E:     cfg_min_e_q <= cfg_data;
				CFG_PHOTON:    cfg_phot_q  <= cfg_data;
				CFG_ELECTRON:  cfg_el_q    <= cfg_data;
				CFG_PAIR_MASS: cfg_pair_q  <= cfg_data[11:0];
				CFG_NBAR_MIN:  cfg_nbar_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			probe_q.e  <= s_axis_tdata[15:0];
			probe_q.px <= s_axis_tdata[31:16];
			probe_q.py <= s_axis_tdata[47:32];
			probe_q.pz <= s_axis_tdata[63:48];
			td_q       <= s_axis_tdata[73:64];
			nc_q       <= s_axis_tdata[81:74];
			dl_q       <= s_axis_tdata[93:82];
			ds_q       <= s_axis_tdata[105:94];
			last_q     <= s_axis_tlast;
			empty_q    <= s_axis_tuser;
		end
		if (state_q == ST_EVAL) begin
			thr_q <= cfg_pair_q * cfg_pair_q;
		end
		if (tag_load) begin
			out_q <= {ovf_q, any_q, (nbar_q >= cfg_nbar_q), pair_q, electron_q, photon_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			k_q         <= '0;
			drain_q     <= '0;
			photon_q    <= 1'b0;
			electron_q  <= 1'b0;
			pair_q      <= 1'b0;
			any_q       <= 1'b0;
			ovf_q       <= 1'b0;
			nbar_q      <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (hit) begin
				pair_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_CLOSE;
					if (take) begin
						any_q <= 1'b1;
						if (probe_q.e > cfg_phot_q) photon_q <= 1'b1;
						if ((td_q < TD_TWO_SIGMA) && (probe_q.e > cfg_el_q)) electron_q <= 1'b1;
						if (nbar_hit && (nbar_q != 8'hFF)) nbar_q <= nbar_q + 8'd1;
						if (!pair_q) begin
							if (td_q < TD_ONE_SIGMA) begin
								if (store_en) count_q <= count_q + CNT_W'(1);
								else ovf_q <= 1'b1;
							end else if (count_q != '0) begin
								k_q     <= '0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					// rotate the full ring so stored entries return to their places
					k_q <= k_q + K_W'(1);
					if (k_q == K_W'(MAX_STORED - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					// hold the closing item while the previous tag still waits
					if (!last_q || tag_load) begin
						state_q <= ST_IDLE;
					end
					if (tag_load) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						photon_q    <= 1'b0;
						electron_q  <= 1'b0;
						pair_q      <= 1'b0;
						any_q       <= 1'b0;
						ovf_q       <= 1'b0;
						nbar_q      <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the calorimeter event trigger filter.
`timescale 1ns / 1ps
module tb_top
	import cet_pkg::*;
;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0]        e;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [9:0]         td;
		logic [7:0]         nc;
		logic [11:0]        dl;
		logic [11:0]        ds;
		logic               last;
		logic               empty;
	} cluster_t;

	typedef struct packed {
		logic photon, electron, pair, nbar, had, ovf;
	} tag_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	calorimeter_event_trigger_filter u_top (.*);

	initial forever #4 clk = ~clk;

	// predictor state
	logic [15:0] min_e, phot_thr, el_thr, nbar_min;
	logic [11:0] pmass;
	entry_t      pair_store[MAX_STORED_DEF];
	int          n_stored, nbar_cnt;
	bit          ph_seen, el_seen, pr_seen, any_seen, ovf_seen;
	tag_t        tag_q[$];
	int          n_err, n_items, n_tags;
	bit          rx_hold;
	bit          rx_fast;

	task automatic clear_event();
		n_stored = 0; nbar_cnt = 0;
		ph_seen = 0; el_seen = 0; pr_seen = 0; any_seen = 0; ovf_seen = 0;
	endtask

	task automatic predict_tag(cluster_t c);
		longint thr, se, sx, sy, sz, m;
		int dsum;
		thr = longint'(pmass) * longint'(pmass);
		dsum = c.dl + c.ds;
		if (!c.empty && c.e > min_e) begin
			any_seen = 1;
			if (c.e > phot_thr) ph_seen = 1;
			if (c.td < 32 && c.e > el_thr) el_seen = 1;
			if (c.nc > 2 && c.dl >= 52 && c.e > 700 && c.td > 32 &&
			    ((c.e < 2000 && dsum > 1152) || (c.e > 2000 && dsum > 1024)))
				if (nbar_cnt < 255) nbar_cnt++;
			if (!pr_seen) begin
				if (c.td < 16) begin
					if (n_stored < MAX_STORED_DEF) begin
						pair_store[n_stored] = '{c.e, c.px, c.py, c.pz};
						n_stored++;
					end else begin
						ovf_seen = 1;
					end
				end else begin
					for (int i = 0; i < n_stored; i++) begin
						se = longint'(pair_store[i].e) + longint'(c.e);
						sx = longint'(pair_store[i].px) + longint'(c.px);
						sy = longint'(pair_store[i].py) + longint'(c.py);
						sz = longint'(pair_store[i].pz) + longint'(c.pz);
						m = se * se - sx * sx - sy * sy - sz * sz;
						if (m > thr) begin
							pr_seen = 1;
							break;
						end
					end
				end
			end
		end
		if (c.last) begin
			tag_q.push_back('{ph_seen, el_seen, pr_seen, nbar_cnt >= nbar_min,
				any_seen, ovf_seen});
			clear_event();
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_E:     min_e = val;
			CFG_PHOTON:    phot_thr = val;
			CFG_ELECTRON:  el_thr = val;
			CFG_PAIR_MASS: pmass = val[11:0];
			CFG_NBAR_MIN:  nbar_min = {8'd0, val[7:0]};
			default: ;
		endcase
	endtask

	// called at a falling edge; leaves at the falling edge after the item is taken
	task automatic send_cluster(cluster_t c, bit no_gap = 0);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (no_gap) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c.ds, c.dl, c.nc, c.td, c.pz, c.py, c.px, c.e};
		s_axis_tlast <= c.last;
		s_axis_tuser <= c.empty;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_tag(c);
		n_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		while (tag_q.size() != 0) @(negedge clk);
		repeat (MAX_STORED_DEF + 10) @(negedge clk);
	endtask

	function automatic cluster_t rand_cluster(bit last, int mode);
		cluster_t c;
		c.e = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
		c.px = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000) - 1500);
		c.py = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000) - 1500);
		c.pz = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000) - 1500);
		c.td = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 48));
		c.nc = 8'($urandom);
		c.dl = ($urandom_range(0, 1)) ? 12'($urandom) : 12'($urandom_range(40, 700));
		c.ds = ($urandom_range(0, 1)) ? 12'($urandom) : 12'($urandom_range(300, 700));
		c.last = last;
		c.empty = ($urandom_range(0, 19) == 0);
		return c;
	endfunction

	// receiver: random stalls, or a long hold-off or always ready when asked
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
			end else if (rx_fast) begin
				m_axis_tready <= 1'b1;
			end else begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
				if (gap == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	// compare each tag with the oldest expectation
	always @(posedge clk) begin
		tag_t got, exp_tag;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[5:0];
			got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
				m_axis_tdata[4], m_axis_tdata[5]};
			n_tags++;
			if (tag_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected tag %b", got);
			end else begin
				exp_tag = tag_q.pop_front();
				if (got !== exp_tag) begin
					n_err++;
					if (n_err <= 10)
						$display("tag %0d: exp ph/el/pr/nb/had/ovf=%b got %b",
							n_tags, exp_tag, got);
				end
			end
		end
	end

	task automatic test_directed();
		cluster_t c;
		// two leptons forming a heavy pair, photon, electron
		c = '{3000, 100, 0, 0, 5, 3, 0, 0, 0, 0}; send_cluster(c);
		c = '{2500, -100, 0, 0, 20, 3, 0, 0, 1, 0}; send_cluster(c);
		// empty event, and an empty item that is not last
		c = '0; c.empty = 1; send_cluster(c);
		c.last = 1; send_cluster(c);
		// energy exactly at min is ignored, just above counts
		c = '0; c.e = 300; c.last = 0; send_cluster(c);
		c.e = 301; c.last = 1; send_cluster(c);
		// antineutron branches: below, at and above the split energy
		c = '{1500, 0, 0, 0, 40, 3, 600, 600, 0, 0}; send_cluster(c);
		c = '{2000, 0, 0, 0, 40, 3, 600, 600, 0, 0}; send_cluster(c);
		c = '{2500, 0, 0, 0, 40, 3, 52, 1000, 1, 0}; send_cluster(c);
		// field extremes
		c = '{16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 10'h3FF, 8'hFF, 12'hFFF,
			12'hFFF, 1, 0}; send_cluster(c);
		c = '{16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0, 0, 0}; send_cluster(c);
		c = '{16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16, 0, 0, 0, 1, 0}; send_cluster(c);
		// fill the store past its depth
		for (int i = 0; i < MAX_STORED_DEF + 2; i++) begin
			c = '{400, 0, 0, 0, 0, 0, 0, 0, 0, 0};
			c.last = (i == MAX_STORED_DEF + 1);
			send_cluster(c, 1);
		end
		s_axis_tvalid <= 1'b0;
		drain();
	endtask

	task automatic run_events(int n_events, int max_len);
		int len, mode;
		for (int ev = 0; ev < n_events; ev++) begin
			len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 80)
				: $urandom_range(1, max_len);
			mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
			for (int k = 0; k < len; k++) send_cluster(rand_cluster(k == len - 1, mode));
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic test_random_cfg();
		write_reg(CFG_MIN_E, 16'($urandom_range(0, 800)));
		write_reg(CFG_PHOTON, 16'($urandom_range(500, 4000)));
		write_reg(CFG_ELECTRON, 16'($urandom_range(300, 3000)));
		write_reg(CFG_PAIR_MASS, 16'($urandom_range(0, 4095)));
		write_reg(CFG_NBAR_MIN, 16'($urandom_range(0, 4)));
		run_events(15, 8);
		drain();
	endtask

	task automatic test_extreme_cfg();
		write_reg(CFG_MIN_E, 16'd0);
		write_reg(CFG_PHOTON, 16'd0);
		write_reg(CFG_ELECTRON, 16'd0);
		write_reg(CFG_PAIR_MASS, 16'd0);
		write_reg(CFG_NBAR_MIN, 16'd0);
		run_events(15, 6);
		drain();
		write_reg(CFG_MIN_E, 16'hFFFF);
		write_reg(CFG_PHOTON, 16'hFFFF);
		write_reg(CFG_ELECTRON, 16'hFFFF);
		write_reg(CFG_PAIR_MASS, 16'h0FFF);
		write_reg(CFG_NBAR_MIN, 16'h00FF);
		run_events(10, 6);
		drain();
		// unused register index is ignored
		write_reg(CFG_UNUSED, 16'h1234);
		write_reg(CFG_MIN_E, RST_MIN_E);
		write_reg(CFG_PAIR_MASS, 16'(RST_PAIR_MASS));
	endtask

	task automatic test_backpressure();
		rx_hold = 1;
		fork
			run_events(20, 2);
			begin
				repeat (3000) @(negedge clk);
				rx_hold = 0;
			end
		join
		drain();
		// sender pauses for every tag, receiver always ready
		rx_fast = 1;
		for (int ev = 0; ev < 10; ev++) begin
			run_events(1, 5);
			while (tag_q.size() != 0) @(negedge clk);
		end
		rx_fast = 0;
		drain();
	endtask

	initial begin
		min_e = RST_MIN_E; phot_thr = RST_PHOTON; el_thr = RST_ELECTRON;
		pmass = RST_PAIR_MASS; nbar_min = RST_NBAR_MIN;
		clear_event();
		n_err = 0; n_items = 0; n_tags = 0; rx_hold = 0; rx_fast = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		run_events(50, 8);
		drain();
		for (int p = 0; p < 4; p++) test_random_cfg();
		test_extreme_cfg();
		test_backpressure();
		$display("covered %0d items and %0d event tags over several threshold settings",
			n_items, n_tags);
		if (n_err == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", n_err);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
design/cet_pkg.sv
design/cet_cell.sv
design/cet_mass.sv
design/calorimeter_event_trigger_filter.sv
bench/tb_top.sv
